/* rtl/kvlp_pkg.sv */
package kvlp_pkg;

  typedef enum logic [2:0] {
    EV_CONSUMED  = 3'd0,
    EV_READY     = 3'd1,
    EV_END       = 3'd2,
    EV_TOO_LONG  = 3'd3,
    EV_NO_EQUALS = 3'd4,
    EV_NO_NAME   = 3'd5,
    EV_STOPPED   = 3'd6,
    EV_READ      = 3'd7
  } ev_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_EOF    = 2'd1,
    KIND_READ   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [7:0] MAX_LEN_RESET = 8'd80;

endpackage

/* rtl/key_value_line_parser_core.sv */
// Byte-serial parser for name=value setting lines.
// Input channel (in_valid/in_stall): each transaction carries a kind, a data
// byte and a line store index. Kind 0 feeds one text byte, kind 1 marks end of
// file, kind 2 reads one entry of the line store.
// Output channel (out_valid/out_stall): exactly one result transaction per
// input transaction, in order, carrying the event code, the current line
// length, the value start index, the stopped flag and the read data.
// Configuration channel (cfg_valid/cfg_ready): writes the line length limit.
// It is always ready and should only be written while the block is idle.
// Each result is registered and valid in the cycle after input acceptance, and
// the block sustains one transaction per cycle while out_stall is low. This
// matches the line store, a synchronous memory whose registered read port
// delivers read data in the cycle after the request.
// While a result waits under out_stall, in_stall is raised and no new
// transaction is taken; results are never dropped.
// Reset clears the parser to seek a line start, clears the stopped flag,
// and sets the limit to 80. The line store is not cleared.
module key_value_line_parser_core #(
  parameter int LINE_CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_res,
  output logic [7:0] out_line_length,
  output logic [7:0] out_value_start,
  output logic       out_stream_ended,
  output logic [7:0] out_read_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_max_line_length
);

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam logic [7:0] CapLimit = 8'(LINE_CAPACITY - 1);
  localparam logic [8:0] CapDepth = 9'(LINE_CAPACITY);

  typedef enum logic [1:0] {
    MODE_SEEK    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_LINE    = 2'd2
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic        stop_r, stop_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        vv_r, vv_nxt;
  logic [7:0]  vi_r, vi_nxt;
  logic [7:0]  max_len_r;

  logic        out_valid_r;
  logic [2:0]  ev_r;
  logic [7:0]  len_r;
  logic [7:0]  vstart_r;
  logic        ended_r;
  logic        rd_ok_r;
  logic [7:0]  rd_q_r;

  logic [7:0]  mem [LINE_CAPACITY];

  logic        adv;
  logic [7:0]  lim;
  kvlp_pkg::ev_t ev;
  logic        we;
  logic [7:0]  wpos;
  logic [7:0]  wdata;
  logic        line_end;
  logic        blank;
  logic        line_char;
  logic        fin;
  logic        fin_eof;
  logic [7:0]  cbase;
  logic        rd_ok;

  assign in_stall  = out_valid_r && out_stall;
  assign adv       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign lim       = (max_len_r > CapLimit) ? CapLimit : max_len_r;
  assign line_end  = (in_data_byte == kvlp_pkg::CH_CR) || (in_data_byte == kvlp_pkg::CH_LF);
  assign blank     = line_end || (in_data_byte == kvlp_pkg::CH_SPACE) ||
                     (in_data_byte == kvlp_pkg::CH_TAB);
  assign rd_ok     = (in_kind == kvlp_pkg::KIND_READ) && ({1'b0, in_read_index} < CapDepth);

  always_comb begin
    mode_nxt  = mode_r;
    stop_nxt  = stop_r;
    cnt_nxt   = cnt_r;
    vv_nxt    = vv_r;
    vi_nxt    = vi_r;
    ev        = kvlp_pkg::EV_CONSUMED;
    we        = 1'b0;
    wpos      = cnt_r;
    wdata     = '0;
    line_char = 1'b0;
    fin       = 1'b0;
    fin_eof   = 1'b0;
    cbase     = cnt_r;

    priority if (in_kind == kvlp_pkg::KIND_READ) begin
      ev = kvlp_pkg::EV_READ;
    end else if (stop_r) begin
      ev = kvlp_pkg::EV_STOPPED;
    end else if (in_kind == kvlp_pkg::KIND_DATA) begin
      unique case (mode_r)
        MODE_COMMENT: begin
          if (line_end) begin
            mode_nxt = MODE_SEEK;
          end
        end
        MODE_LINE: begin
          if (line_end) begin
            fin = 1'b1;
          end else begin
            line_char = 1'b1;
          end
        end
        MODE_SEEK: begin
          if (in_data_byte == kvlp_pkg::CH_HASH) begin
            mode_nxt = MODE_COMMENT;
          end else if (!blank) begin
            cbase     = '0;
            cnt_nxt   = '0;
            vv_nxt    = 1'b0;
            vi_nxt    = '0;
            mode_nxt  = MODE_LINE;
            line_char = 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_SEEK;
        end
      endcase
    end else if (in_kind == kvlp_pkg::KIND_EOF) begin
      if (mode_r == MODE_LINE) begin
        fin     = 1'b1;
        fin_eof = 1'b1;
      end else begin
        stop_nxt = 1'b1;
        ev       = kvlp_pkg::EV_END;
      end
    end else begin
      ev = kvlp_pkg::EV_CONSUMED;
    end

    if (line_char) begin
      we   = 1'b1;
      wpos = cbase;
      if (cbase >= lim) begin
        wdata    = '0;
        stop_nxt = 1'b1;
        ev       = kvlp_pkg::EV_TOO_LONG;
      end else begin
        cnt_nxt = cbase + 8'd1;
        if (in_data_byte == kvlp_pkg::CH_EQUALS) begin
          wdata  = '0;
          vi_nxt = cbase + 8'd1;
          vv_nxt = 1'b1;
        end else begin
          wdata = in_data_byte;
        end
      end
    end

    if (fin) begin
      we       = 1'b1;
      wpos     = cnt_r;
      wdata    = '0;
      mode_nxt = MODE_SEEK;
      priority if (!vv_r) begin
        stop_nxt = 1'b1;
        ev       = kvlp_pkg::EV_NO_EQUALS;
      end else if (vi_r == 8'd1) begin
        stop_nxt = 1'b1;
        ev       = kvlp_pkg::EV_NO_NAME;
      end else begin
        if (fin_eof) begin
          stop_nxt = 1'b1;
        end
        ev = kvlp_pkg::EV_READY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SEEK;
      stop_r      <= 1'b0;
      cnt_r       <= '0;
      vv_r        <= 1'b0;
      vi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        mode_r <= mode_nxt;
        stop_r <= stop_nxt;
        cnt_r  <= cnt_nxt;
        vv_r   <= vv_nxt;
        vi_r   <= vi_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= kvlp_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_line_length;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ev_r     <= ev;
      len_r    <= cnt_nxt;
      vstart_r <= vv_nxt ? vi_nxt : 8'd0;
      ended_r  <= stop_nxt;
      rd_ok_r  <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && we && ({1'b0, wpos} < CapDepth)) begin
      mem[wpos[AW-1:0]] <= wdata;
    end
    if (adv && rd_ok) begin
      rd_q_r <= mem[in_read_index[AW-1:0]];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_line_length  = len_r;
  assign out_value_start  = vstart_r;
  assign out_stream_ended = ended_r;
  assign out_read_byte    = rd_ok_r ? rd_q_r : 8'd0;

endmodule

/* rtl/kvlp_checker.sv */
module kvlp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_event_res,
  input logic       out_stream_ended,
  input logic [7:0] out_read_byte
);

  // The input side only waits while a result is held back.
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("in_stall raised with no pending result");

  // Every accepted transaction yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

  // Terminal events always report the stream as ended.
  a_terminal_ended: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res == kvlp_pkg::EV_END ||
                   out_event_res == kvlp_pkg::EV_TOO_LONG ||
                   out_event_res == kvlp_pkg::EV_NO_EQUALS ||
                   out_event_res == kvlp_pkg::EV_NO_NAME ||
                   out_event_res == kvlp_pkg::EV_STOPPED)) |-> out_stream_ended)
    else $error("terminal event without stream_ended");

  // Read data is only nonzero on read results.
  a_read_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != kvlp_pkg::EV_READ) |-> (out_read_byte == 8'd0))
    else $error("read_byte nonzero on a non-read result");

  // A stalled result stays in place.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_event_res)))
    else $error("stalled result changed");

endmodule

bind key_value_line_parser_core kvlp_checker u_kvlp_checker (.*);
